// ===== hdl/hsf_pkg.sv =====
// ----------------------------------------------------------------------------
// hsf_pkg
// Shared widths, register map codes and sequencer states of the scaled HMM
// forward step.
// ----------------------------------------------------------------------------
package hsf_pkg;

  // Number of states that take part in the sums (2..4); the ports always carry four.
  localparam int NumStates = 4;
  localparam int MaxStates = 4;
  localparam int StateIdxW = $clog2(NumStates);

  localparam int ProbW   = 16;               // Q0.16 probability
  localparam int LikW    = 16;
  localparam int AlphaW  = 16;
  localparam int RegW    = 64;               // four packed lanes
  localparam int AccW    = 34;               // sum of four 16x16 products
  localparam int FactW   = AccW - ProbW;     // predicted factor after >>16
  localparam int WeightW = FactW + LikW;
  localparam int ScaleW  = WeightW + 2;
  localparam int QuotW   = AlphaW + 1;       // one extra bit shows the whole scale
  localparam int CntW    = $clog2(QuotW);
  localparam int PaddrW  = 6;

  localparam logic [RegW-1:0] RegReset = 64'h4000_4000_4000_4000;

  // register indexes, paddr[5:3]
  localparam logic [2:0] RegInit   = 3'd0;
  localparam logic [2:0] RegTrans0 = 3'd1;
  localparam logic [2:0] RegTrans1 = 3'd2;
  localparam logic [2:0] RegTrans2 = 3'd3;
  localparam logic [2:0] RegTrans3 = 3'd4;

  typedef enum logic [2:0] {
    StIdle,
    StPred,
    StWeight,
    StSum,
    StDiv,
    StFinish
  } state_e;

endpackage

// ===== hdl/hmm_scaled_forward_step_core.sv =====
// ----------------------------------------------------------------------------
// hmm_scaled_forward_step_core
// Scaled forward filter step: predict, weight by likelihood, sum and
// normalize by a bit-serial restoring division in four parallel lanes.
// ----------------------------------------------------------------------------
// One request is processed at a time. A request with first_step set skips the
// prediction; any other request first steps through the source states, one per
// cycle, to form it. Then come the weights, the scale sum and the restoring
// divider, which retires one quotient bit per lane per cycle, and last the load
// of the output register. A result waiting in the output register does not
// hold off the next request until that request finishes.
module hmm_scaled_forward_step_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hsf_pkg::PaddrW-1:0]          paddr,
  input  logic [hsf_pkg::RegW-1:0]            pwdata,
  output logic [hsf_pkg::RegW-1:0]            prdata,
  output logic                                pready,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                first_step_i,
  input  logic [hsf_pkg::LikW-1:0]            lik_0_i,
  input  logic [hsf_pkg::LikW-1:0]            lik_1_i,
  input  logic [hsf_pkg::LikW-1:0]            lik_2_i,
  input  logic [hsf_pkg::LikW-1:0]            lik_3_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [hsf_pkg::AlphaW-1:0]          alpha_0_o,
  output logic [hsf_pkg::AlphaW-1:0]          alpha_1_o,
  output logic [hsf_pkg::AlphaW-1:0]          alpha_2_o,
  output logic [hsf_pkg::AlphaW-1:0]          alpha_3_o,
  output logic [hsf_pkg::ScaleW-1:0]          step_scale_o,
  output logic                                zero_sum_o
);

  localparam int MS = hsf_pkg::MaxStates;

  // configuration
  logic [hsf_pkg::RegW-1:0] init_q;
  logic [hsf_pkg::RegW-1:0] trans_q [MS];
  logic                     cfg_we;

  // control
  hsf_pkg::state_e              state_q, state_d;
  logic [hsf_pkg::StateIdxW-1:0] j_q;
  logic [hsf_pkg::CntW-1:0]     cnt_q;
  logic                         out_valid_q;
  logic [hsf_pkg::AlphaW-1:0]   prev_q [MS];

  logic in_accept, pred_en, weight_en, sum_en, div_en, load_out;
  logic pred_last, div_last;

  // datapath
  logic                          first_q;
  logic [hsf_pkg::LikW-1:0]      lik_q     [MS];
  logic [hsf_pkg::RegW-1:0]      row_sh_q  [MS];
  logic [hsf_pkg::AlphaW-1:0]    pa_sh_q   [MS];
  logic [hsf_pkg::AccW-1:0]      acc_q     [MS];
  logic [hsf_pkg::WeightW-1:0]   w_q       [MS];
  logic [hsf_pkg::ScaleW-1:0]    scale_q;
  logic [hsf_pkg::ScaleW-1:0]    rem_q     [MS];
  logic [hsf_pkg::QuotW-1:0]     quo_q     [MS];
  logic [hsf_pkg::AlphaW-1:0]    alpha_q   [MS];
  logic [hsf_pkg::ScaleW-1:0]    scale_out_q;
  logic                          zero_q;

  logic [2*hsf_pkg::ProbW-1:0]   pred_prod [MS];
  logic [hsf_pkg::FactW-1:0]     factor    [MS];
  logic [hsf_pkg::WeightW-1:0]   weight_d  [MS];
  logic [hsf_pkg::ScaleW-1:0]    scale_d;
  logic [hsf_pkg::ScaleW:0]      trial     [MS];
  logic                          ge        [MS];
  logic [hsf_pkg::AlphaW-1:0]    alpha_d   [MS];
  logic [hsf_pkg::LikW-1:0]      lik_in    [MS];
  logic                          zero_d;

  assign lik_in[0] = lik_0_i;
  assign lik_in[1] = lik_1_i;
  assign lik_in[2] = lik_2_i;
  assign lik_in[3] = lik_3_i;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= hsf_pkg::RegReset;
      for (int i = 0; i < MS; i++) begin
        trans_q[i] <= hsf_pkg::RegReset;
      end
    end else if (cfg_we) begin
      unique case (paddr[5:3])
        hsf_pkg::RegInit:   init_q     <= pwdata;
        hsf_pkg::RegTrans0: trans_q[0] <= pwdata;
        hsf_pkg::RegTrans1: trans_q[1] <= pwdata;
        hsf_pkg::RegTrans2: trans_q[2] <= pwdata;
        hsf_pkg::RegTrans3: trans_q[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      hsf_pkg::RegInit:   prdata = init_q;
      hsf_pkg::RegTrans0: prdata = trans_q[0];
      hsf_pkg::RegTrans1: prdata = trans_q[1];
      hsf_pkg::RegTrans2: prdata = trans_q[2];
      hsf_pkg::RegTrans3: prdata = trans_q[3];
      default:            prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign pred_last = (j_q == hsf_pkg::StateIdxW'(hsf_pkg::NumStates - 1));
  assign div_last  = (cnt_q == hsf_pkg::CntW'(hsf_pkg::QuotW - 1));

  always_comb begin
    state_d    = state_q;
    in_accept  = 1'b0;
    pred_en    = 1'b0;
    weight_en  = 1'b0;
    sum_en     = 1'b0;
    div_en     = 1'b0;
    load_out   = 1'b0;
    in_ready_o = 1'b0;
    unique case (state_q)
      hsf_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          in_accept = 1'b1;
          // a first step needs no prediction
          state_d   = first_step_i ? hsf_pkg::StWeight : hsf_pkg::StPred;
        end
      end
      hsf_pkg::StPred: begin
        pred_en = 1'b1;
        if (pred_last) state_d = hsf_pkg::StWeight;
      end
      hsf_pkg::StWeight: begin
        weight_en = 1'b1;
        state_d   = hsf_pkg::StSum;
      end
      hsf_pkg::StSum: begin
        sum_en  = 1'b1;
        state_d = hsf_pkg::StDiv;
      end
      hsf_pkg::StDiv: begin
        div_en = 1'b1;
        if (div_last) state_d = hsf_pkg::StFinish;
      end
      hsf_pkg::StFinish: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = hsf_pkg::StIdle;
        end
      end
      default: state_d = hsf_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hsf_pkg::StIdle;
      j_q         <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MS; i++) begin
        prev_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (in_accept) j_q <= '0;
      else if (pred_en) j_q <= j_q + 1'b1;
      if (sum_en) cnt_q <= '0;
      else if (div_en) cnt_q <= cnt_q + 1'b1;
      if (load_out) begin
        out_valid_q <= 1'b1;
        for (int i = 0; i < MS; i++) begin
          prev_q[i] <= alpha_d[i];
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath lanes
  // --------------------------------------------------------------------------
  always_comb begin
    scale_d = '0;
    zero_d  = (scale_q == '0);
    for (int k = 0; k < MS; k++) begin
      pred_prod[k] = row_sh_q[0][k*hsf_pkg::ProbW +: hsf_pkg::ProbW] * pa_sh_q[0];
      factor[k]    = first_q ? hsf_pkg::FactW'(init_q[k*hsf_pkg::ProbW +: hsf_pkg::ProbW])
                             : acc_q[k][hsf_pkg::AccW-1:hsf_pkg::ProbW];
      weight_d[k]  = (k < hsf_pkg::NumStates) ? factor[k] * lik_q[k] : '0;
      scale_d      = scale_d + hsf_pkg::ScaleW'(w_q[k]);
      // first quotient bit compares the weight itself, later ones the doubled rest
      trial[k]     = (cnt_q == '0) ? {1'b0, rem_q[k]} : {rem_q[k], 1'b0};
      ge[k]        = (trial[k] >= {1'b0, scale_q});
      if (zero_d || k >= hsf_pkg::NumStates) begin
        alpha_d[k] = '0;
      end else if (quo_q[k][hsf_pkg::QuotW-1]) begin
        alpha_d[k] = '1;
      end else begin
        alpha_d[k] = quo_q[k][hsf_pkg::AlphaW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      first_q <= first_step_i;
      for (int k = 0; k < MS; k++) begin
        lik_q[k]    <= lik_in[k];
        row_sh_q[k] <= trans_q[k];
        pa_sh_q[k]  <= prev_q[k];
        acc_q[k]    <= '0;
      end
    end
    if (pred_en) begin
      // advance one source state per cycle through the row and alpha shifters
      for (int k = 0; k < MS; k++) begin
        acc_q[k] <= acc_q[k] + hsf_pkg::AccW'(pred_prod[k]);
      end
      for (int k = 0; k < MS - 1; k++) begin
        row_sh_q[k] <= row_sh_q[k+1];
        pa_sh_q[k]  <= pa_sh_q[k+1];
      end
    end
    if (weight_en) begin
      for (int k = 0; k < MS; k++) begin
        w_q[k] <= weight_d[k];
      end
    end
    if (sum_en) begin
      scale_q <= scale_d;
      for (int k = 0; k < MS; k++) begin
        rem_q[k] <= hsf_pkg::ScaleW'(w_q[k]);
      end
    end
    if (div_en) begin
      for (int k = 0; k < MS; k++) begin
        rem_q[k] <= ge[k] ? hsf_pkg::ScaleW'(trial[k] - {1'b0, scale_q})
                          : hsf_pkg::ScaleW'(trial[k]);
        quo_q[k] <= {quo_q[k][hsf_pkg::QuotW-2:0], ge[k]};
      end
    end
    if (load_out) begin
      scale_out_q <= scale_q;
      zero_q      <= zero_d;
      for (int k = 0; k < MS; k++) begin
        alpha_q[k] <= alpha_d[k];
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign alpha_0_o    = alpha_q[0];
  assign alpha_1_o    = alpha_q[1];
  assign alpha_2_o    = alpha_q[2];
  assign alpha_3_o    = alpha_q[3];
  assign step_scale_o = scale_out_q;
  assign zero_sum_o   = zero_q;

endmodule

// ===== hdl/hsf_checker.sv =====
// ----------------------------------------------------------------------------
// hsf_checker
// Port-level checks of the forward step core, bound to its top level.
// ----------------------------------------------------------------------------
module hsf_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [hsf_pkg::AlphaW-1:0] alpha_0_o,
  input logic [hsf_pkg::AlphaW-1:0] alpha_1_o,
  input logic [hsf_pkg::AlphaW-1:0] alpha_2_o,
  input logic [hsf_pkg::AlphaW-1:0] alpha_3_o,
  input logic [hsf_pkg::ScaleW-1:0] step_scale_o,
  input logic                       zero_sum_o
);

  // a request keeps the core busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("core ready right after accepting a request");

  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (zero_sum_o == (step_scale_o == '0)))
    else $error("zero_sum does not match step_scale");

  a_zero_alphas: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_sum_o |->
      (alpha_0_o == '0) && (alpha_1_o == '0) && (alpha_2_o == '0) && (alpha_3_o == '0))
    else $error("nonzero alpha with zero scale");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(step_scale_o) && $stable(alpha_0_o) && $stable(alpha_3_o))
    else $error("stalled result changed or dropped");

endmodule

bind hmm_scaled_forward_step_core hsf_checker u_hsf_checker (.*);

// ===== sim/hmm_scaled_forward_step_checker.sv =====
// ----------------------------------------------------------------------------
// hmm_scaled_forward_step_checker
// Watches the register port and both stream channels of the scaled forward
// step, predicts the alphas, scale and zero flag of every accepted request
// and compares them with the results in the order they leave the block.
// ----------------------------------------------------------------------------
module hmm_scaled_forward_step_checker
  import hsf_pkg::*;
(
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [PaddrW-1:0]               paddr,
  input  logic [RegW-1:0]                 pwdata,
  input  logic                            pready,
  input  logic                            in_valid_i,
  input  logic                            in_ready_o,
  input  logic                            first_step_i,
  input  logic [LikW-1:0]                 lik_0_i,
  input  logic [LikW-1:0]                 lik_1_i,
  input  logic [LikW-1:0]                 lik_2_i,
  input  logic [LikW-1:0]                 lik_3_i,
  input  logic                            out_valid_o,
  input  logic                            out_ready_i,
  input  logic [AlphaW-1:0]               alpha_0_o,
  input  logic [AlphaW-1:0]               alpha_1_o,
  input  logic [AlphaW-1:0]               alpha_2_o,
  input  logic [AlphaW-1:0]               alpha_3_o,
  input  logic [ScaleW-1:0]               step_scale_o,
  input  logic                            zero_sum_o,
  output int                              fail_count_o,
  output int                              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [MaxStates-1:0][AlphaW-1:0] alpha;
    logic [ScaleW-1:0]                scale;
    logic                             zero_sum;
  } step_result_t;

  step_result_t   expected_steps [$];
  logic [RegW-1:0]   init_probs;
  logic [RegW-1:0]   trans_rows [MaxStates];
  logic [AlphaW-1:0] prev_alpha [MaxStates];
  int mismatches   = 0;
  int accepted_cnt = 0;
  int retired_cnt  = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = accepted_cnt - retired_cnt;

  // One forward step; advances the stored alphas.
  function automatic step_result_t forward_step(input logic first,
                                                input logic [MaxStates-1:0][LikW-1:0] lik);
    step_result_t res;
    logic [63:0]  weight [MaxStates];
    logic [63:0]  scale;
    logic [63:0]  factor;
    logic [63:0]  acc;
    logic [63:0]  quo;
    scale = '0;
    for (int k = 0; k < MaxStates; k++) weight[k] = '0;
    for (int k = 0; k < NumStates; k++) begin
      if (first) begin
        factor = 64'(init_probs[ProbW*k +: ProbW]);
      end else begin
        acc = '0;
        for (int j = 0; j < NumStates; j++) begin
          acc += 64'(trans_rows[j][ProbW*k +: ProbW]) * 64'(prev_alpha[j]);
        end
        factor = acc >> 16;
      end
      weight[k] = factor * 64'(lik[k]);
      scale += weight[k];
    end
    for (int k = 0; k < MaxStates; k++) begin
      quo = '0;
      if (scale != 0 && k < NumStates) begin
        quo = (weight[k] << 16) / scale;
        if (quo > 64'hFFFF) quo = 64'hFFFF;
      end
      res.alpha[k]  = quo[AlphaW-1:0];
      prev_alpha[k] = quo[AlphaW-1:0];
    end
    res.scale    = scale[ScaleW-1:0];
    res.zero_sum = (scale == 0);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    step_result_t                     want;
    logic [MaxStates-1:0][AlphaW-1:0] got_alpha;
    if (!rst_ni) begin
      init_probs = RegReset;
      for (int k = 0; k < MaxStates; k++) begin
        trans_rows[k] = RegReset;
        prev_alpha[k] = '0;
      end
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[PaddrW-1:3])
          RegInit:   init_probs    = pwdata;
          RegTrans0: trans_rows[0] = pwdata;
          RegTrans1: trans_rows[1] = pwdata;
          RegTrans2: trans_rows[2] = pwdata;
          RegTrans3: trans_rows[3] = pwdata;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        expected_steps.push_back(forward_step(first_step_i,
                                              {lik_3_i, lik_2_i, lik_1_i, lik_0_i}));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (out_valid_o && out_ready_i) begin
        got_alpha = {alpha_3_o, alpha_2_o, alpha_1_o, alpha_0_o};
        if (expected_steps.size() == 0) begin
          $display("%0t: result expected none, actual alphas %0d %0d %0d %0d scale %0d",
                   $time, alpha_0_o, alpha_1_o, alpha_2_o, alpha_3_o, step_scale_o);
          mismatches++;
        end else begin
          want = expected_steps.pop_front();
          retired_cnt <= retired_cnt + 1;
          for (int k = 0; k < MaxStates; k++) begin
            check_field($sformatf("alpha_%0d", k), 64'(want.alpha[k]), 64'(got_alpha[k]));
          end
          check_field("step_scale", 64'(want.scale), 64'(step_scale_o));
          check_field("zero_sum", 64'(want.zero_sum), 64'(zero_sum_o));
        end
      end
    end
  end

endmodule

// ===== sim/hmm_scaled_forward_step_core_test.sv =====
// ----------------------------------------------------------------------------
// hmm_scaled_forward_step_core_test
// Drives the scaled forward step with directed corner requests and random
// observation sequences under several register settings, with random gaps on
// the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module hmm_scaled_forward_step_core_test;
  import hsf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [MaxStates-1:0][LikW-1:0] lik_vec_t;

  typedef enum {
    CfgReset,
    CfgZero,
    CfgOnes,
    CfgRandom,
    CfgStochastic,
    CfgOneHot
  } cfg_mode_e;

  localparam logic [2:0] RegUnmapped   = RegTrans3 + 3'd1;
  localparam int         NumPhases     = 12;
  localparam int         ItemsPerPhase = 140;
  localparam int         TailCycles    = 64;

  logic               clk_i;
  logic               rst_ni       = 1'b0;
  logic               psel         = 1'b0;
  logic               penable      = 1'b0;
  logic               pwrite       = 1'b0;
  logic [PaddrW-1:0]  paddr        = '0;
  logic [RegW-1:0]    pwdata       = '0;
  logic [RegW-1:0]    prdata;
  logic               pready;
  logic               in_valid_i   = 1'b0;
  logic               in_ready_o;
  logic               first_step_i = 1'b0;
  logic [LikW-1:0]    lik_0_i      = '0;
  logic [LikW-1:0]    lik_1_i      = '0;
  logic [LikW-1:0]    lik_2_i      = '0;
  logic [LikW-1:0]    lik_3_i      = '0;
  logic               out_valid_o;
  logic               out_ready_i  = 1'b0;
  logic [AlphaW-1:0]  alpha_0_o;
  logic [AlphaW-1:0]  alpha_1_o;
  logic [AlphaW-1:0]  alpha_2_o;
  logic [AlphaW-1:0]  alpha_3_o;
  logic [ScaleW-1:0]  step_scale_o;
  logic               zero_sum_o;
  int                 fail_count;
  int                 pending;

  hmm_scaled_forward_step_core dut (.*);

  hmm_scaled_forward_step_checker checker_i (
    .*,
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int pick_gap(input bit no_gaps);
    int roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 75) return 0;
    if (roll < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic lik_vec_t random_lik();
    lik_vec_t v;
    if ($urandom_range(0, 31) == 0) return '0;
    for (int k = 0; k < MaxStates; k++) begin
      case ($urandom_range(0, 19))
        0, 1:    v[k] = '0;
        2, 3:    v[k] = '1;
        4, 5, 6: v[k] = LikW'($urandom_range(1, 15));
        default: v[k] = LikW'($urandom);
      endcase
    end
    return v;
  endfunction

  function automatic logic [RegW-1:0] cfg_value(input cfg_mode_e mode);
    logic [RegW-1:0] v;
    case (mode)
      CfgReset:  v = RegReset;
      CfgZero:   v = '0;
      CfgOnes:   v = '1;
      CfgRandom: v = {$urandom, $urandom};
      CfgStochastic: begin
        for (int k = 0; k < MaxStates; k++) v[ProbW*k +: ProbW] = ProbW'($urandom_range(0, 16383));
      end
      default:   v = RegW'(64'hFFFF) << (ProbW * $urandom_range(0, MaxStates - 1));
    endcase
    return v;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [RegW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input cfg_mode_e mode);
    for (int r = RegInit; r <= RegTrans3; r++) write_reg(3'(r), cfg_value(mode));
    // an address past the map must leave every register alone
    write_reg(RegUnmapped, {$urandom, $urandom});
  endtask

  // Let the last acceptance be counted, then wait until all results are back.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic send_step(input logic first, input lik_vec_t lik, input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    first_step_i <= first;
    lik_0_i      <= lik[0];
    lik_1_i      <= lik[1];
    lik_2_i      <= lik[2];
    lik_3_i      <= lik[3];
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic run_directed();
    // steps before any first step and after a zero sum predict from zero alphas
    send_step(1'b0, random_lik(), 0);
    send_step(1'b1, '0, 0);
    send_step(1'b0, '1, pick_gap(1'b0));
    send_step(1'b1, '1, 0);
    send_step(1'b0, '1, pick_gap(1'b0));
    // whole scale in one state saturates
    send_step(1'b1, {16'h0000, 16'h0000, 16'h0000, 16'hFFFF}, 0);
    send_step(1'b0, {16'h0001, 16'h0000, 16'h0000, 16'h0000}, 0);
    send_step(1'b0, '1, 0);
    send_step(1'b1, {16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}, pick_gap(1'b0));
    send_step(1'b0, {16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA}, 0);
    send_step(1'b1, {16'h0001, 16'h0001, 16'h0001, 16'h0001}, 0);
    send_step(1'b0, {16'h0000, 16'h0000, 16'h0001, 16'h0000}, 0);
    send_step(1'b0, '0, 0);
    send_step(1'b0, '1, 0);
    drain();
    configure(CfgOnes);
    send_step(1'b1, '1, 0);
    send_step(1'b0, '1, 0);
    send_step(1'b0, '1, 0);
    drain();
    configure(CfgZero);
    send_step(1'b1, '1, 0);
    send_step(1'b0, '1, 0);
  endtask

  task automatic run_random(input int n, input bit no_gaps);
    int sent;
    int run_len;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: arbitrary first flag, breaks up sequences
        send_step(1'($urandom), random_lik(), pick_gap(no_gaps));
        sent++;
      end else begin
        run_len = $urandom_range(0, 30);
        send_step(1'b1, random_lik(), pick_gap(no_gaps));
        sent++;
        for (int i = 0; i < run_len && sent < n; i++) begin
          send_step(1'b0, random_lik(), pick_gap(no_gaps));
          sent++;
        end
      end
    end
  endtask

  initial begin
    wait (rst_ni);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      out_ready_i <= 1'b0;
      if ($urandom_range(0, 99) < 85) repeat ($urandom_range(1, 3)) @(posedge clk_i);
      else repeat ($urandom_range(20, 80)) @(posedge clk_i);
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int p = 0; p < NumPhases; p++) begin
      drain();
      configure(cfg_mode_e'(p % 6));
      run_random(ItemsPerPhase, p % 4 == 3);
    end
    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
